### hdl/grrt_pkg.sv
// ============================================================================
// grrt_pkg
// Shared status codes, register indices and output widths for the grid RRT step engine.
// ============================================================================
package grrt_pkg;

    localparam logic [2:0] ST_OBS_STORED = 3'd0;
    localparam logic [2:0] ST_OBS_HIT    = 3'd1;
    localparam logic [2:0] ST_DUPLICATE  = 3'd2;
    localparam logic [2:0] ST_NODE_ADDED = 3'd3;
    localparam logic [2:0] ST_PATH       = 3'd4;
    localparam logic [2:0] ST_TREE_FULL  = 3'd5;
    localparam logic [2:0] ST_OBS_FULL   = 3'd6;
    localparam logic [2:0] ST_FINISHED   = 3'd7;

    localparam logic [1:0] REG_START_X = 2'd0;
    localparam logic [1:0] REG_START_Y = 2'd1;
    localparam logic [1:0] REG_GOAL_X  = 2'd2;
    localparam logic [1:0] REG_GOAL_Y  = 2'd3;

    localparam int OUT_IDX_BITS = 6;
    localparam int OUT_XY_BITS  = 8;

endpackage

### hdl/grrt_node_mem.sv
// ============================================================================
// grrt_node_mem
// Node table: x, y and parent per entry, one write and one registered read.
// ============================================================================
module grrt_node_mem
    import grrt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [CW-1:0] wx,
    input  logic [CW-1:0] wy,
    input  logic [AW-1:0] wpar,
    input  logic [AW-1:0] raddr,
    output logic [CW-1:0] rx,
    output logic [CW-1:0] ry,
    output logic [AW-1:0] rpar
);

    logic [2*CW+AW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wx, wy, wpar};
        end
        {rx, ry, rpar} <= mem[raddr];
    end

endmodule

### hdl/grrt_obs_mem.sv
// ============================================================================
// grrt_obs_mem
// Obstacle table: x and y per entry, one write and one registered read.
// ============================================================================
module grrt_obs_mem
    import grrt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [CW-1:0] wx,
    input  logic [CW-1:0] wy,
    input  logic [AW-1:0] raddr,
    output logic [CW-1:0] rx,
    output logic [CW-1:0] ry
);

    logic [2*CW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wx, wy};
        end
        {rx, ry} <= mem[raddr];
    end

endmodule

### hdl/grid_rrt_step_engine_core.sv
// ============================================================================
// grid_rrt_step_engine_core
// Grid RRT growth engine with node and obstacle tables in block memories.
// ============================================================================
// Usage:
//   Configure start/goal over the APB port while idle (regs at 0,4,8,12).
//   Issue a transaction by raising start with func, cell_x, cell_y while
//   busy is low. busy stays high until the last result has been strobed.
//   Each result appears for one cycle with strobe high; last marks the final
//   result of a transaction. The receiver cannot stall.
//   Steps: an obstacle item is stored directly. A sample item takes one memory
//   read per node for the nearest search, a step toward the sample, one read
//   per obstacle and one per node for the collision scans, then a write,
//   plus a root write when the tree is empty. A goal path reads its entries
//   one at a time through the single node table read port. One transaction
//   at a time.
//   Reset clears the node and obstacle counts, the finished flag and the
//   configuration registers; table contents are left undefined.
// ============================================================================
module grid_rrt_step_engine_core
    import grrt_pkg::*;
#(
    parameter int MAX_NODES     = 64,
    parameter int MAX_OBSTACLES = 16,
    parameter int COORD_BITS    = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [7:0]  cell_x,
    input  logic [7:0]  cell_y,
    output logic        strobe,
    output logic [2:0]  status,
    output logic [7:0]  out_x,
    output logic [7:0]  out_y,
    output logic [5:0]  node_index,
    output logic        last
);

    localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int OAW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int OCW = $clog2(MAX_OBSTACLES + 1);
    localparam int IW  = (NCW > OCW) ? NCW : OCW;
    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NEAR  = 4'd1;
    localparam logic [3:0] S_NRD   = 4'd2;
    localparam logic [3:0] S_OBS   = 4'd3;
    localparam logic [3:0] S_DUP   = 4'd4;
    localparam logic [3:0] S_ADD   = 4'd5;
    localparam logic [3:0] S_PRD   = 4'd6;
    localparam logic [3:0] S_PEMIT = 4'd7;
    localparam logic [3:0] S_ROOT  = 4'd8;

    logic [7:0] start_x_reg, start_y_reg, goal_x_reg, goal_y_reg;
    logic [3:0] state_reg, state_next;
    logic [NCW-1:0] ncount_reg, ncount_next;
    logic [OCW-1:0] ocount_reg, ocount_next;
    logic fin_reg, fin_next;
    logic [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [CW-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic [IW-1:0] i_reg, i_next;
    logic rv_reg, rv_next;
    logic [NAW-1:0] ri_reg, ri_next;
    logic [DW-1:0] best_reg, best_next;
    logic bvalid_reg, bvalid_next;
    logic [NAW-1:0] near_reg, near_next;
    logic [NCW-1:0] k_reg, k_next;
    logic hit_reg, hit_next;
    logic [NAW-1:0] pidx_reg, pidx_next;

    logic strobe_reg, strobe_next;
    logic [2:0] status_reg, status_next;
    logic [7:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [5:0] oi_reg, oi_next;
    logic last_reg, last_next;

    logic n_we;
    logic [NAW-1:0] n_waddr, n_raddr, n_wpar, n_rpar;
    logic [CW-1:0] n_wx, n_wy, n_rx, n_ry;
    logic o_we;
    logic [OAW-1:0] o_raddr;
    logic [CW-1:0] o_rx, o_ry;

    grrt_node_mem #(.DEPTH(MAX_NODES), .AW(NAW), .CW(CW)) u_nodes (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wx(n_wx), .wy(n_wy),
        .wpar(n_wpar), .raddr(n_raddr), .rx(n_rx), .ry(n_ry), .rpar(n_rpar)
    );

    grrt_obs_mem #(.DEPTH(MAX_OBSTACLES), .AW(OAW), .CW(CW)) u_obs (
        .clk(clk), .we(o_we), .waddr(ocount_reg[OAW-1:0]), .wx(cx_reg),
        .wy(cy_reg), .raddr(o_raddr), .rx(o_rx), .ry(o_ry)
    );

    // configuration port
    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            goal_x_reg  <= '0;
            goal_y_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_START_X: start_x_reg <= pwdata[7:0];
                REG_START_Y: start_y_reg <= pwdata[7:0];
                REG_GOAL_X:  goal_x_reg  <= pwdata[7:0];
                REG_GOAL_Y:  goal_y_reg  <= pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_START_X: prdata = {24'd0, start_x_reg};
            REG_START_Y: prdata = {24'd0, start_y_reg};
            REG_GOAL_X:  prdata = {24'd0, goal_x_reg};
            REG_GOAL_Y:  prdata = {24'd0, goal_y_reg};
        endcase
    end

    // datapath helpers
    logic [DW-1:0] man_dist;
    logic [CW-1:0] adx, ady, ncx, ncy;
    assign adx  = (cx_reg > n_rx) ? cx_reg - n_rx : n_rx - cx_reg;
    assign ady  = (cy_reg > n_ry) ? cy_reg - n_ry : n_ry - cy_reg;
    assign man_dist = DW'(adx) + DW'(ady);
    assign ncx  = (n_rx < cx_reg) ? n_rx + 1'b1 : (n_rx > cx_reg) ? n_rx - 1'b1 : n_rx;
    assign ncy  = (n_ry < cy_reg) ? n_ry + 1'b1 : (n_ry > cy_reg) ? n_ry - 1'b1 : n_ry;

    always_comb
    begin
        state_next  = state_reg;
        ncount_next = ncount_reg;
        ocount_next = ocount_reg;
        fin_next    = fin_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        tx_next     = tx_reg;
        ty_next     = ty_reg;
        i_next      = i_reg;
        rv_next     = 1'b0;
        ri_next     = ri_reg;
        best_next   = best_reg;
        bvalid_next = bvalid_reg;
        near_next   = near_reg;
        k_next      = k_reg;
        hit_next    = hit_reg;
        pidx_next   = pidx_reg;
        strobe_next = 1'b0;
        status_next = status_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oi_next     = oi_reg;
        last_next   = 1'b1;
        n_we        = 1'b0;
        n_waddr     = '0;
        n_wx        = CW'(start_x_reg);
        n_wy        = CW'(start_y_reg);
        n_wpar      = '0;
        n_raddr     = i_reg[NAW-1:0];
        o_we        = 1'b0;
        o_raddr     = i_reg[OAW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !strobe_reg)
                begin
                    cx_next = CW'(cell_x);
                    cy_next = CW'(cell_y);
                    ox_next = 8'(CW'(cell_x));
                    oy_next = 8'(CW'(cell_y));
                    oi_next = '0;
                    i_next  = '0;
                    if (fin_reg)
                    begin
                        strobe_next = 1'b1;
                        status_next = ST_FINISHED;
                    end
                    else if (!func)
                    begin
                        if (ocount_reg >= OCW'(MAX_OBSTACLES))
                        begin
                            strobe_next = 1'b1;
                            status_next = ST_OBS_FULL;
                        end
                        else
                        begin
                            state_next = S_ADD;
                            hit_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = (ncount_reg == '0) ? S_ROOT : S_NEAR;
                        bvalid_next = 1'b0;
                    end
                end
            end
            S_ROOT:
            begin
                n_we        = 1'b1;
                ncount_next = NCW'(1);
                state_next  = S_NEAR;
            end
            S_NEAR:
            begin
                if (rv_reg && (!bvalid_reg || man_dist <= best_reg))
                begin
                    best_next   = man_dist;
                    bvalid_next = 1'b1;
                    near_next   = ri_reg;
                end
                if (i_reg < ncount_reg)
                begin
                    n_raddr = i_reg[NAW-1:0];
                    ri_next = i_reg[NAW-1:0];
                    rv_next = 1'b1;
                    i_next  = i_reg + 1'b1;
                end
                else if (!rv_reg)
                begin
                    state_next = S_NRD;
                end
            end
            S_NRD:
            begin
                n_raddr = near_reg;
                rv_next = 1'b1;
                if (rv_reg)
                begin
                    tx_next    = ncx;
                    ty_next    = ncy;
                    i_next     = '0;
                    rv_next    = 1'b0;
                    hit_next   = 1'b0;
                    state_next = S_OBS;
                end
            end
            S_OBS:
            begin
                if (rv_reg && o_rx == tx_reg && o_ry == ty_reg)
                begin
                    hit_next = 1'b1;
                end
                if (!hit_next && i_reg < IW'(ocount_reg) && i_reg < IW'(MAX_OBSTACLES))
                begin
                    o_raddr = i_reg[OAW-1:0];
                    rv_next = 1'b1;
                    i_next  = i_reg + 1'b1;
                end
                else if (hit_next)
                begin
                    strobe_next = 1'b1;
                    status_next = ST_OBS_HIT;
                    ox_next     = 8'(tx_reg);
                    oy_next     = 8'(ty_reg);
                    oi_next     = 6'(near_reg);
                    state_next  = S_IDLE;
                end
                else if (!rv_reg)
                begin
                    i_next     = '0;
                    state_next = S_DUP;
                end
            end
            S_DUP:
            begin
                if (rv_reg && n_rx == tx_reg && n_ry == ty_reg)
                begin
                    strobe_next = 1'b1;
                    status_next = ST_DUPLICATE;
                    ox_next     = 8'(tx_reg);
                    oy_next     = 8'(ty_reg);
                    oi_next     = 6'(ri_reg);
                    state_next  = S_IDLE;
                end
                else if (i_reg < ncount_reg)
                begin
                    n_raddr = i_reg[NAW-1:0];
                    ri_next = i_reg[NAW-1:0];
                    rv_next = 1'b1;
                    i_next  = i_reg + 1'b1;
                end
                else if (!rv_reg)
                begin
                    hit_next   = 1'b0;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                state_next = S_IDLE;
                strobe_next = 1'b1;
                if (hit_reg)
                begin
                    o_we        = 1'b1;
                    ocount_next = ocount_reg + 1'b1;
                    status_next = ST_OBS_STORED;
                end
                else
                begin
                    ox_next = 8'(tx_reg);
                    oy_next = 8'(ty_reg);
                    if (ncount_reg >= NCW'(MAX_NODES))
                    begin
                        status_next = ST_TREE_FULL;
                        oi_next     = 6'(near_reg);
                    end
                    else
                    begin
                        n_we        = 1'b1;
                        n_waddr     = ncount_reg[NAW-1:0];
                        n_wx        = tx_reg;
                        n_wy        = ty_reg;
                        n_wpar      = near_reg;
                        ncount_next = ncount_reg + 1'b1;
                        oi_next     = 6'(ncount_reg[NAW-1:0]);
                        if (tx_reg != CW'(goal_x_reg) || ty_reg != CW'(goal_y_reg))
                        begin
                            status_next = ST_NODE_ADDED;
                        end
                        else
                        begin
                            strobe_next = 1'b0;
                            fin_next    = 1'b1;
                            pidx_next   = ncount_reg[NAW-1:0];
                            k_next      = '0;
                            state_next  = S_PRD;
                        end
                    end
                end
            end
            S_PRD:
            begin
                n_raddr    = pidx_reg;
                state_next = S_PEMIT;
            end
            S_PEMIT:
            begin
                strobe_next = 1'b1;
                status_next = ST_PATH;
                ox_next     = 8'(n_rx);
                oy_next     = 8'(n_ry);
                oi_next     = 6'(pidx_reg);
                k_next      = k_reg + 1'b1;
                if (pidx_reg == '0 || k_reg >= NCW'(MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    last_next  = 1'b0;
                    pidx_next  = n_rpar;
                    state_next = S_PRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ncount_reg <= '0;
            ocount_reg <= '0;
            fin_reg    <= 1'b0;
            rv_reg     <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ncount_reg <= ncount_next;
            ocount_reg <= ocount_next;
            fin_reg    <= fin_next;
            rv_reg     <= rv_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;
        i_reg      <= i_next;
        ri_reg     <= ri_next;
        best_reg   <= best_next;
        bvalid_reg <= bvalid_next;
        near_reg   <= near_next;
        k_reg      <= k_next;
        hit_reg    <= hit_next;
        pidx_reg   <= pidx_next;
        status_reg <= status_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        oi_reg     <= oi_next;
        last_reg   <= last_next;
    end

    assign busy       = (state_reg != S_IDLE) | strobe_reg;
    assign strobe     = strobe_reg;
    assign status     = status_reg;
    assign out_x      = ox_reg;
    assign out_y      = oy_reg;
    assign node_index = oi_reg;
    assign last       = last_reg;

endmodule

### bench/tb.sv
// ============================================================================
// tb
// Self-checking bench for the grid RRT step engine.
// Obstacles and samples go in through the command port. Each transaction
// is run through an in-bench model of tree growth, which yields the
// expected statuses, cells, indexes and path entries. Every strobed result
// is checked against them in order. Directed cases come first, then random
// phases with different start/goal settings and idle patterns. The run
// ends with a goal hit that emits the path, and with items sent after that.
// ============================================================================
module tb;
    import grrt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       f;
        logic [7:0] x;
        logic [7:0] y;
    } cmd_t;

    typedef struct packed {
        logic [2:0] st;
        logic [7:0] x;
        logic [7:0] y;
        logic [5:0] idx;
        logic       last;
    } res_t;

    localparam int NODES = 64;
    localparam int OBSTS = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic        func = 1'b0;
    logic [7:0]  cell_x = '0;
    logic [7:0]  cell_y = '0;
    logic        strobe;
    logic [2:0]  status;
    logic [7:0]  out_x;
    logic [7:0]  out_y;
    logic [5:0]  node_index;
    logic        last;

    grid_rrt_step_engine_core uut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    cmd_t pending_cmds[$];
    res_t expected_results[$];
    int   errors = 0;
    int   send_idle_pct = 0;

    // tree model state
    logic [7:0] cfg_sx, cfg_sy, cfg_gx, cfg_gy;
    logic [7:0] tree_x[NODES];
    logic [7:0] tree_y[NODES];
    logic [5:0] tree_par[NODES];
    int         tree_count = 0;
    logic [7:0] obst_x[OBSTS];
    logic [7:0] obst_y[OBSTS];
    int         obst_count = 0;
    bit         done = 1'b0;

    function automatic logic [7:0] step_to(logic [7:0] a, logic [7:0] b);
        if (a < b)
            return a + 8'd1;
        if (a > b)
            return a - 8'd1;
        return a;
    endfunction

    // nearest node (later wins ties) and the stepped cell
    function automatic void aim(input logic [7:0] x, input logic [7:0] y,
                                output int near, output logic [7:0] tx,
                                output logic [7:0] ty);
        int best;
        int d;
        best = 32'h7fffffff;
        near = 0;
        for (int i = 0; i < tree_count; i++)
        begin
            d = ((x > tree_x[i]) ? x - tree_x[i] : tree_x[i] - x)
              + ((y > tree_y[i]) ? y - tree_y[i] : tree_y[i] - y);
            if (d <= best)
            begin
                best = d;
                near = i;
            end
        end
        tx = step_to(tree_x[near], x);
        ty = step_to(tree_y[near], y);
    endfunction

    function automatic int find_obstacle(logic [7:0] x, logic [7:0] y);
        for (int i = 0; i < obst_count; i++)
            if (obst_x[i] == x && obst_y[i] == y)
                return i;
        return -1;
    endfunction

    function automatic int find_node(logic [7:0] x, logic [7:0] y);
        for (int i = 0; i < tree_count; i++)
            if (tree_x[i] == x && tree_y[i] == y)
                return i;
        return -1;
    endfunction

    function automatic void expect_one(logic [2:0] st, logic [7:0] x, logic [7:0] y,
                                       int idx, logic lst);
        res_t r;
        r.st = st;
        r.x = x;
        r.y = y;
        r.idx = idx[5:0];
        r.last = lst;
        expected_results = {expected_results, r};
    endfunction

    function automatic void grow_tree(cmd_t c);
        int near;
        int hit;
        int idx;
        int k;
        logic [7:0] tx, ty;
        bit is_root;
        if (done)
        begin
            expect_one(ST_FINISHED, c.x, c.y, 0, 1'b1);
            return;
        end
        if (!c.f)
        begin
            if (obst_count >= OBSTS)
                expect_one(ST_OBS_FULL, c.x, c.y, 0, 1'b1);
            else
            begin
                obst_x[obst_count] = c.x;
                obst_y[obst_count] = c.y;
                obst_count++;
                expect_one(ST_OBS_STORED, c.x, c.y, 0, 1'b1);
            end
            return;
        end
        if (tree_count == 0)
        begin
            tree_x[0] = cfg_sx;
            tree_y[0] = cfg_sy;
            tree_par[0] = '0;
            tree_count = 1;
        end
        aim(c.x, c.y, near, tx, ty);
        if (find_obstacle(tx, ty) >= 0)
        begin
            expect_one(ST_OBS_HIT, tx, ty, near, 1'b1);
            return;
        end
        hit = find_node(tx, ty);
        if (hit >= 0)
        begin
            expect_one(ST_DUPLICATE, tx, ty, hit, 1'b1);
            return;
        end
        if (tree_count >= NODES)
        begin
            expect_one(ST_TREE_FULL, tx, ty, near, 1'b1);
            return;
        end
        idx = tree_count;
        tree_x[idx] = tx;
        tree_y[idx] = ty;
        tree_par[idx] = near[5:0];
        tree_count++;
        if (tx != cfg_gx || ty != cfg_gy)
        begin
            expect_one(ST_NODE_ADDED, tx, ty, idx, 1'b1);
            return;
        end
        done = 1'b1;
        k = 0;
        forever
        begin
            is_root = (idx == 0 || k >= NODES - 1);
            expect_one(ST_PATH, tree_x[idx], tree_y[idx], idx, is_root);
            k++;
            if (is_root)
                break;
            idx = int'(tree_par[idx]);
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            grow_tree(pending_cmds[0]);
            void'(pending_cmds.pop_front());
        end
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            start  <= 1'b1;
            func   <= pending_cmds[0].f;
            cell_x <= pending_cmds[0].x;
            cell_y <= pending_cmds[0].y;
        end
        else
            start <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        res_t w;
        if (rst_n && strobe)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, status", 32'(status), 32'd0);
            else
            begin
                w = expected_results.pop_front();
                if (status !== w.st)
                    report_mismatch("status", 32'(status), 32'(w.st));
                if (out_x !== w.x)
                    report_mismatch("out_x", 32'(out_x), 32'(w.x));
                if (out_y !== w.y)
                    report_mismatch("out_y", 32'(out_y), 32'(w.y));
                if (node_index !== w.idx)
                    report_mismatch("node_index", 32'(node_index), 32'(w.idx));
                if (last !== w.last)
                    report_mismatch("last", 32'(last), 32'(w.last));
            end
        end
    end

    task automatic issue(logic f, logic [7:0] x, logic [7:0] y);
        cmd_t c;
        wait (pending_cmds.size() == 0);
        c.f = f;
        c.x = x;
        c.y = y;
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic settle();
        wait (pending_cmds.size() == 0 && expected_results.size() == 0);
        @(posedge clk);
        while (start || busy)
            @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_X: cfg_sx = val;
            REG_START_Y: cfg_sy = val;
            REG_GOAL_X:  cfg_gx = val;
            default:     cfg_gy = val;
        endcase
    endtask

    task automatic configure(logic [7:0] sx, logic [7:0] sy, logic [7:0] gx,
                             logic [7:0] gy);
        settle();
        reg_write(REG_START_X, sx);
        reg_write(REG_START_Y, sy);
        reg_write(REG_GOAL_X, gx);
        reg_write(REG_GOAL_Y, gy);
    endtask

    task automatic random_item();
        int r;
        int k;
        int nx, ny;
        r = $urandom_range(99);
        if (r < 15)
            issue(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)));
        else if (r < 55 || tree_count >= 60)
        begin
            k = $urandom_range(tree_count - 1);
            issue(1'b1, tree_x[k], tree_y[k]);
        end
        else if (r < 75)
            issue(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)));
        else
        begin
            k = $urandom_range(tree_count - 1);
            nx = int'(tree_x[k]) + $urandom_range(6) - 3;
            ny = int'(tree_y[k]) + $urandom_range(6) - 3;
            nx = nx < 0 ? 0 : (nx > 255 ? 255 : nx);
            ny = ny < 0 ? 0 : (ny > 255 ? 255 : ny);
            issue(1'b1, 8'(nx), 8'(ny));
        end
    endtask

    initial
    begin
        int modes[4] = '{0, 73, 0, 32};
        int near;
        logic [7:0] tx, ty, sx, sy;
        cfg_sx = '0;
        cfg_sy = '0;
        cfg_gx = '0;
        cfg_gy = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // goal sits on an obstacle, so the tree cannot finish yet
        configure(8'd0, 8'd255, 8'd0, 8'd0);
        issue(1'b0, 8'd0, 8'd0);
        issue(1'b0, 8'd255, 8'd255);
        issue(1'b0, 8'd1, 8'd254);
        issue(1'b1, 8'd0, 8'd255);
        issue(1'b1, 8'd200, 8'd100);
        issue(1'b1, 8'd0, 8'd0);
        issue(1'b1, 8'd255, 8'd255);
        issue(1'b1, 8'd0, 8'd200);
        issue(1'b1, 8'd0, 8'd255);
        for (int i = 0; i < 13; i++)
            issue(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)));
        issue(1'b0, 8'd85, 8'd170);
        issue(1'b1, 8'd3, 8'd250);

        for (int p = 0; p < 4; p++)
        begin
            if (p == 2)
                configure(8'd255, 8'd0, 8'd255, 8'd255);
            else if (p > 0)
                configure(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'd0, 8'd0);
            settle();
            send_idle_pct = modes[p];
            for (int i = 0; i < 52; i++)
                random_item();
        end

        // pick a sample that will add a node and make that cell the goal
        settle();
        send_idle_pct = 0;
        forever
        begin
            sx = 8'($urandom_range(255));
            sy = 8'($urandom_range(255));
            aim(sx, sy, near, tx, ty);
            if (find_obstacle(tx, ty) < 0 && find_node(tx, ty) < 0 && tree_count < NODES)
                break;
        end
        configure(8'd0, 8'd255, tx, ty);
        issue(1'b1, sx, sy);
        issue(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)));
        issue(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)));

        settle();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
